// ===== rtl/binned_color_mode_vote_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for binned_color_mode_vote_core
// Each macro takes a label, a clock, an active-low reset and its terms.
// ----------------------------------------------------------------------------
`ifndef BINNED_COLOR_MODE_VOTE_CORE_MACROS_SVH
`define BINNED_COLOR_MODE_VOTE_CORE_MACROS_SVH

// a must hold at every edge out of reset
`define BCMV_ASSERT_ALWAYS(label, clk, rst_n, a) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a)) \
		else $error("assertion failed");

// a implies b in the same cycle
`define BCMV_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// a implies b in the next cycle
`define BCMV_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// ===== rtl/bcmv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmv_pkg
// Types and constants shared by the binned color mode vote blocks.
// ----------------------------------------------------------------------------
package bcmv_pkg;

	localparam int CH_W        = 8;
	localparam int CH_MAX      = 255;
	localparam int KEY_CH_W    = 5;
	localparam int KEY_W       = 3 * KEY_CH_W;
	localparam int WCNT_W      = 6;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		logic [CH_W-1:0] vote_red;
		logic [CH_W-1:0] vote_green;
		logic [CH_W-1:0] vote_blue;
		logic            last_vote;
	} vote_t;

	typedef struct packed {
		logic [CH_W-1:0]   mean_red;
		logic [CH_W-1:0]   mean_green;
		logic [CH_W-1:0]   mean_blue;
		logic [WCNT_W-1:0] winning_count;
	} result_t;

	typedef struct packed {
		vote_t vote;
		key_t  key;
	} qent_t;

	typedef enum logic [2:0] {
		ST_VOTE,
		ST_DRAIN,
		ST_SCAN,
		ST_DIV,
		ST_OUT
	} back_state_t;

	function automatic key_t bin_key(vote_t v);
		return {v.vote_red[CH_W-1 -: KEY_CH_W], v.vote_green[CH_W-1 -: KEY_CH_W],
			v.vote_blue[CH_W-1 -: KEY_CH_W]};
	endfunction

endpackage

// ===== rtl/bcmv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmv_front
// Takes vote words, tags each with its bin key and queues them for the back.
// ----------------------------------------------------------------------------
module bcmv_front (
	input  logic            clk,
	input  logic            arst_n,
	input  bcmv_pkg::vote_t vote,
	input  logic            vote_valid,
	output logic            vote_stall,
	output bcmv_pkg::qent_t deq_entry,
	output logic            deq_valid,
	input  logic            deq_pop
);
	import bcmv_pkg::*;

	qent_t             fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign vote_stall = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign deq_valid  = (cnt_q != '0);
	assign deq_entry  = fifo_q[rd_ptr_q];
	assign push       = vote_valid && !vote_stall;
	assign pop        = deq_pop && deq_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{vote: vote, key: bin_key(vote)};
		end
	end

endmodule

// ===== rtl/bcmv_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmv_div
// Three-lane restoring divider, one quotient bit per lane per cycle.
// ----------------------------------------------------------------------------
module bcmv_div #(
	parameter int MAX_VOTES = 32,
	localparam int CNT_W  = $clog2(MAX_VOTES + 1),
	localparam int SUM_W  = $clog2(MAX_VOTES * bcmv_pkg::CH_MAX + 1),
	localparam int ITER_W = $clog2(SUM_W)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [SUM_W-1:0]          sum_red,
	input  logic [SUM_W-1:0]          sum_green,
	input  logic [SUM_W-1:0]          sum_blue,
	input  logic [CNT_W-1:0]          cnt,
	output logic                      done,
	output logic [bcmv_pkg::CH_W-1:0] mean_red,
	output logic [bcmv_pkg::CH_W-1:0] mean_green,
	output logic [bcmv_pkg::CH_W-1:0] mean_blue
);
	import bcmv_pkg::*;

	localparam int LANES = 3;

	logic [SUM_W-1:0]  dvd   [LANES];
	logic [SUM_W-1:0]  quo_q [LANES];
	logic [CNT_W-1:0]  rem_q [LANES];
	logic [SUM_W-1:0]  quo_d [LANES];
	logic [CNT_W-1:0]  rem_d [LANES];
	logic [CNT_W:0]    shifted [LANES];
	logic [CNT_W:0]    diff  [LANES];
	logic              ge    [LANES];
	logic [CNT_W-1:0]  dvs_q;
	logic [ITER_W-1:0] iter_q;
	logic              busy_q;
	logic              done_q;

	assign dvd[0] = sum_red;
	assign dvd[1] = sum_green;
	assign dvd[2] = sum_blue;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			shifted[l] = {rem_q[l], quo_q[l][SUM_W-1]};
			diff[l]    = shifted[l] - {1'b0, dvs_q};
			ge[l]      = (shifted[l] >= {1'b0, dvs_q});
			rem_d[l]   = ge[l] ? diff[l][CNT_W-1:0] : shifted[l][CNT_W-1:0];
			quo_d[l]   = {quo_q[l][SUM_W-2:0], ge[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == ITER_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= cnt;
			for (int l = 0; l < LANES; l++) begin
				quo_q[l] <= dvd[l];
				rem_q[l] <= '0;
			end
		end else if (busy_q) begin
			for (int l = 0; l < LANES; l++) begin
				quo_q[l] <= quo_d[l];
				rem_q[l] <= rem_d[l];
			end
		end
	end

	assign done       = done_q;
	assign mean_red   = quo_q[0][CH_W-1:0];
	assign mean_green = quo_q[1][CH_W-1:0];
	assign mean_blue  = quo_q[2][CH_W-1:0];

endmodule

// ===== rtl/bcmv_back.sv =====
`timescale 1ns / 1ps
`include "binned_color_mode_vote_core_macros.svh"
// ----------------------------------------------------------------------------
// bcmv_back
// Bin table: key match, count and sum update, winner scan, divider control.
// ----------------------------------------------------------------------------
module bcmv_back #(
	parameter int MAX_VOTES = 32,
	localparam int CNT_W = $clog2(MAX_VOTES + 1),
	localparam int IDX_W = (MAX_VOTES > 1) ? $clog2(MAX_VOTES) : 1,
	localparam int SUM_W = $clog2(MAX_VOTES * bcmv_pkg::CH_MAX + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bcmv_pkg::qent_t             deq_entry,
	input  logic                        deq_valid,
	output logic                        deq_pop,
	output logic                        div_start,
	output logic [SUM_W-1:0]            div_sum_red,
	output logic [SUM_W-1:0]            div_sum_green,
	output logic [SUM_W-1:0]            div_sum_blue,
	output logic [CNT_W-1:0]            div_cnt,
	input  logic                        div_done,
	output logic                        res_valid,
	output logic [bcmv_pkg::WCNT_W-1:0] res_count,
	input  logic                        res_take
);
	import bcmv_pkg::*;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [SUM_W-1:0] sum_red;
		logic [SUM_W-1:0] sum_green;
		logic [SUM_W-1:0] sum_blue;
	} bin_t;

	back_state_t          state_q;
	back_state_t          state_d;
	key_t                 key_q [MAX_VOTES];
	bin_t                 mem_q [MAX_VOTES];
	logic [CNT_W-1:0]     used_q;
	logic [CNT_W-1:0]     taken_q;
	logic [MAX_VOTES-1:0] match;
	logic                 hit;
	logic [IDX_W-1:0]     slot_hit;
	logic [IDX_W-1:0]     slot;
	logic                 ignore;
	logic                 take;
	logic                 upd_s1;
	logic                 new_s1;
	logic [IDX_W-1:0]     slot_s1;
	vote_t                vote_s1;
	bin_t                 rd_q;
	bin_t                 base;
	bin_t                 wr_data;
	logic                 byp_valid_q;
	logic [IDX_W-1:0]     byp_addr_q;
	bin_t                 byp_data_q;
	logic [IDX_W-1:0]     rd_addr;
	logic [CNT_W-1:0]     scan_addr_q;
	logic                 scan_issue;
	logic                 scan_done;
	logic                 scan_s1;
	logic                 scan_first_s1;
	bin_t                 best_q;

	always_comb begin
		slot_hit = '0;
		for (int i = 0; i < MAX_VOTES; i++) begin
			match[i] = (CNT_W'(i) < used_q) && (key_q[i] == deq_entry.key);
			if (match[i]) begin
				slot_hit = slot_hit | IDX_W'(i);
			end
		end
	end

	assign hit     = |match;
	assign slot    = hit ? slot_hit : used_q[IDX_W-1:0];
	assign ignore  = (taken_q >= CNT_W'(MAX_VOTES));
	assign deq_pop = deq_valid && (state_q == ST_VOTE);
	assign take    = deq_pop && !ignore;

	always_comb begin
		if (new_s1) begin
			base = '0;
		end else if (byp_valid_q && (byp_addr_q == slot_s1)) begin
			base = byp_data_q;
		end else begin
			base = rd_q;
		end
		wr_data.cnt       = base.cnt + 1'b1;
		wr_data.sum_red   = base.sum_red + SUM_W'(vote_s1.vote_red);
		wr_data.sum_green = base.sum_green + SUM_W'(vote_s1.vote_green);
		wr_data.sum_blue  = base.sum_blue + SUM_W'(vote_s1.vote_blue);
	end

	assign scan_issue = (state_q == ST_SCAN) && (scan_addr_q < used_q);
	assign scan_done  = (state_q == ST_SCAN) && !scan_issue && !scan_s1;
	assign rd_addr    = (state_q == ST_SCAN) ? scan_addr_q[IDX_W-1:0] : slot;

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			ST_VOTE: begin
				if (deq_pop && deq_entry.vote.last_vote) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (res_take) begin
					state_d = ST_VOTE;
				end
			end
			default: begin
				state_d = ST_VOTE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_VOTE;
			used_q      <= '0;
			taken_q     <= '0;
			upd_s1      <= 1'b0;
			byp_valid_q <= 1'b0;
			scan_addr_q <= '0;
			scan_s1     <= 1'b0;
		end else begin
			state_q     <= state_d;
			upd_s1      <= take;
			byp_valid_q <= upd_s1;
			scan_s1     <= scan_issue;
			if ((state_q == ST_OUT) && res_take) begin
				used_q  <= '0;
				taken_q <= '0;
			end else if (take) begin
				taken_q <= taken_q + 1'b1;
				if (!hit) begin
					used_q <= used_q + 1'b1;
				end
			end
			if (state_q != ST_SCAN) begin
				scan_addr_q <= '0;
			end else if (scan_issue) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !hit) begin
			key_q[slot] <= deq_entry.key;
		end
		slot_s1       <= slot;
		new_s1        <= !hit;
		vote_s1       <= deq_entry.vote;
		byp_addr_q    <= slot_s1;
		byp_data_q    <= wr_data;
		scan_first_s1 <= (scan_addr_q == '0);
		if (scan_s1 && (scan_first_s1 || (rd_q.cnt > best_q.cnt))) begin
			best_q <= rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_s1) begin
			mem_q[slot_s1] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign div_sum_red   = best_q.sum_red;
	assign div_sum_green = best_q.sum_green;
	assign div_sum_blue  = best_q.sum_blue;
	assign div_cnt       = best_q.cnt;
	assign res_valid     = (state_q == ST_OUT);
	assign res_count     = WCNT_W'(best_q.cnt);

	`BCMV_ASSERT_IMPLIES(a_key_unique, clk, arst_n, deq_valid, $onehot0(match))
	`BCMV_ASSERT_ALWAYS(a_fill_bound, clk, arst_n, used_q <= taken_q && taken_q <= CNT_W'(MAX_VOTES))
	`BCMV_ASSERT_IMPLIES(a_scan_quiet, clk, arst_n, state_q == ST_SCAN, !upd_s1)
	`BCMV_ASSERT_IMPLIES(a_winner_nonempty, clk, arst_n, state_q == ST_OUT, best_q.cnt != '0)
	`BCMV_ASSERT_NEXT(a_table_cleared, clk, arst_n, state_q == ST_OUT && res_take, used_q == '0 && taken_q == '0)

endmodule

// ===== rtl/binned_color_mode_vote_core.sv =====
// Votes: one word per cycle while the two-entry queue has room.
// When a last vote leaves the queue the back drains, then makes one winner-scan read per bin in use,
// then one divider step per bit of sum width (13 steps at 32 votes); then it gives its result.
// The back takes no vote while that result is formed; the queue takes up to two more meanwhile.
// Reset is asynchronous: the table reads empty at once, no clearing pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binned_color_mode_vote_core
// Mode vote over 15-bit color bins with per-channel mean of the winner.
// ----------------------------------------------------------------------------
module binned_color_mode_vote_core #(
	parameter int MAX_VOTES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bcmv_pkg::vote_t   vote,
	input  logic              vote_valid,
	output logic              vote_stall,
	output bcmv_pkg::result_t result,
	output logic              result_valid,
	input  logic              result_stall
);
	import bcmv_pkg::*;

	localparam int CNT_W = $clog2(MAX_VOTES + 1);
	localparam int SUM_W = $clog2(MAX_VOTES * CH_MAX + 1);

	qent_t             deq_entry;
	logic              deq_valid;
	logic              deq_pop;
	logic              div_start;
	logic [SUM_W-1:0]  div_sum_red;
	logic [SUM_W-1:0]  div_sum_green;
	logic [SUM_W-1:0]  div_sum_blue;
	logic [CNT_W-1:0]  div_cnt;
	logic              div_done;
	logic [CH_W-1:0]   mean_red;
	logic [CH_W-1:0]   mean_green;
	logic [CH_W-1:0]   mean_blue;
	logic              res_valid;
	logic [WCNT_W-1:0] res_count;
	logic              res_take;
	logic              out_valid_q;
	result_t           result_q;

	bcmv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.vote       (vote),
		.vote_valid (vote_valid),
		.vote_stall (vote_stall),
		.deq_entry  (deq_entry),
		.deq_valid  (deq_valid),
		.deq_pop    (deq_pop)
	);

	bcmv_back #(.MAX_VOTES(MAX_VOTES)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.deq_entry     (deq_entry),
		.deq_valid     (deq_valid),
		.deq_pop       (deq_pop),
		.div_start     (div_start),
		.div_sum_red   (div_sum_red),
		.div_sum_green (div_sum_green),
		.div_sum_blue  (div_sum_blue),
		.div_cnt       (div_cnt),
		.div_done      (div_done),
		.res_valid     (res_valid),
		.res_count     (res_count),
		.res_take      (res_take)
	);

	bcmv_div #(.MAX_VOTES(MAX_VOTES)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.sum_red    (div_sum_red),
		.sum_green  (div_sum_green),
		.sum_blue   (div_sum_blue),
		.cnt        (div_cnt),
		.done       (div_done),
		.mean_red   (mean_red),
		.mean_green (mean_green),
		.mean_blue  (mean_blue)
	);

	assign res_take = res_valid && (!out_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			result_q.mean_red      <= mean_red;
			result_q.mean_green    <= mean_green;
			result_q.mean_blue     <= mean_blue;
			result_q.winning_count <= res_count;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives vote sets into binned_color_mode_vote_core and predicts each set's
// winner: bins keyed by the top five bits per channel, the earliest bin wins
// ties, votes past the table cap are dropped. Every result word is checked
// against the prediction under random idling, a long receiver hold-off and a
// phase with no idling at all.
// ----------------------------------------------------------------------------
module tb;
	import bcmv_pkg::*;

	localparam int TABLE_DEPTH  = 32;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 400000;

	logic    clk = 1'b0;
	logic    arst_n;
	vote_t   vote;
	logic    vote_valid;
	logic    vote_stall;
	result_t result;
	logic    result_valid;
	logic    result_stall = 1'b0;

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int unsigned hold_ticket   = 0;
	int unsigned ticket_seen   = 0;
	int unsigned hold_left     = 0;
	int unsigned cycles        = 0;
	int          errors        = 0;

	key_t        tally_key   [TABLE_DEPTH];
	logic [5:0]  tally_count [TABLE_DEPTH];
	logic [12:0] tally_red   [TABLE_DEPTH];
	logic [12:0] tally_green [TABLE_DEPTH];
	logic [12:0] tally_blue  [TABLE_DEPTH];
	logic [5:0]  tally_bins  = '0;
	logic [5:0]  tally_votes = '0;
	result_t     expected_means[$];
	result_t     expected_now;

	key_t palette [4];
	int   palette_size = 1;

	binned_color_mode_vote_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.vote         (vote),
		.vote_valid   (vote_valid),
		.vote_stall   (vote_stall),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off when a new ticket shows up
	always @(negedge clk) begin
		if (hold_ticket != ticket_seen) begin
			ticket_seen = hold_ticket;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// bin the vote; on the last one of a set, queue the winner's means
	function automatic void tally_vote(input vote_t v);
		key_t    k;
		int      slot;
		int      best;
		result_t mean;
		k = {v.vote_red[7:3], v.vote_green[7:3], v.vote_blue[7:3]};
		if (tally_votes < TABLE_DEPTH) begin
			slot = int'(tally_bins);
			for (int i = int'(tally_bins) - 1; i >= 0; i--)
				if (tally_key[i] == k)
					slot = i;
			if (slot == tally_bins) begin
				tally_key[slot]   = k;
				tally_count[slot] = '0;
				tally_red[slot]   = '0;
				tally_green[slot] = '0;
				tally_blue[slot]  = '0;
				tally_bins++;
			end
			tally_count[slot]++;
			tally_red[slot]   += 13'(v.vote_red);
			tally_green[slot] += 13'(v.vote_green);
			tally_blue[slot]  += 13'(v.vote_blue);
			tally_votes++;
		end
		if (v.last_vote) begin
			best = 0;
			for (int i = 1; i < tally_bins; i++)
				if (tally_count[i] > tally_count[best])
					best = i;
			mean.mean_red      = 8'(tally_red[best] / tally_count[best]);
			mean.mean_green    = 8'(tally_green[best] / tally_count[best]);
			mean.mean_blue     = 8'(tally_blue[best] / tally_count[best]);
			mean.winning_count = tally_count[best];
			expected_means = {expected_means, mean};
			tally_bins  = '0;
			tally_votes = '0;
		end
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_means.size() == 0) begin
				$error("result word with no vote set pending: %h", result);
				errors++;
			end else begin
				expected_now = expected_means.pop_front();
				check_field("mean_red", expected_now.mean_red, result.mean_red);
				check_field("mean_green", expected_now.mean_green, result.mean_green);
				check_field("mean_blue", expected_now.mean_blue, result.mean_blue);
				check_field("winning_count", 8'(expected_now.winning_count),
					8'(result.winning_count));
			end
		end
	end

	// entered and left at a falling edge; valid stays up between words unless the bench idles
	task automatic send_vote(input vote_t v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			vote_valid <= 1'b0;
			@(negedge clk);
		end
		vote       <= v;
		vote_valid <= 1'b1;
		@(posedge clk);
		while (vote_stall)
			@(posedge clk);
		tally_vote(v);
		@(negedge clk);
	endtask

	function automatic vote_t rgb(input logic [7:0] r, g, b, input logic last);
		vote_t v;
		v.vote_red   = r;
		v.vote_green = g;
		v.vote_blue  = b;
		v.last_vote  = last;
		return v;
	endfunction

	function automatic vote_t pick_color();
		vote_t v;
		key_t  k;
		k = palette[$urandom_range(0, palette_size - 1)];
		if ($urandom_range(0, 4) == 0) begin
			v.vote_red   = 8'($urandom_range(0, 255));
			v.vote_green = 8'($urandom_range(0, 255));
			v.vote_blue  = 8'($urandom_range(0, 255));
		end else begin
			v.vote_red[7:3]   = k[14:10];
			v.vote_green[7:3] = k[9:5];
			v.vote_blue[7:3]  = k[4:0];
			v.vote_red[2:0]   = 3'($urandom_range(0, 7));
			v.vote_green[2:0] = 3'($urandom_range(0, 7));
			v.vote_blue[2:0]  = 3'($urandom_range(0, 7));
		end
		v.last_vote = 1'b0;
		return v;
	endfunction

	// a set drawn from a few bins so that counts pile up
	task automatic send_set(input int len);
		vote_t v;
		palette_size = $urandom_range(1, 4);
		for (int i = 0; i < 4; i++)
			palette[i] = key_t'($urandom_range(0, 32767));
		for (int i = 0; i < len; i++) begin
			v           = pick_color();
			v.last_vote = (i == len - 1);
			send_vote(v);
		end
	endtask

	task automatic test_extremes();
		send_vote(rgb(8'h00, 8'h00, 8'h00, 1'b1));
		send_vote(rgb(8'hFF, 8'hFF, 8'hFF, 1'b1));
		send_vote(rgb(8'hAA, 8'h55, 8'hAA, 1'b0));
		send_vote(rgb(8'h55, 8'hAA, 8'h55, 1'b1));
	endtask

	// equal counts: the bin created first wins; low bits mix within a bin
	task automatic test_ties();
		send_vote(rgb(8'd100, 8'd100, 8'd100, 1'b0));
		send_vote(rgb(8'd16, 8'd200, 8'd40, 1'b0));
		send_vote(rgb(8'd23, 8'd207, 8'd47, 1'b0));
		send_vote(rgb(8'd103, 8'd101, 8'd98, 1'b1));
	endtask

	task automatic test_majority();
		send_vote(rgb(8'd10, 8'd20, 8'd30, 1'b0));
		send_vote(rgb(8'd250, 8'd5, 8'd128, 1'b0));
		send_vote(rgb(8'd249, 8'd7, 8'd135, 1'b0));
		send_vote(rgb(8'd64, 8'd64, 8'd64, 1'b0));
		send_vote(rgb(8'd255, 8'd0, 8'd130, 1'b1));
	endtask

	task automatic test_random_sets(input int votes);
		int sent;
		int len;
		sent = 0;
		while (sent < votes) begin
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
			send_set(len);
			sent += len;
		end
	endtask

	// receiver holds off while sets keep coming, so the input backs up
	task automatic test_backpressure();
		hold_ticket <= hold_ticket + 1;
		for (int s = 0; s < 10; s++)
			send_set(4);
	endtask

	task automatic test_vote_overflow();
		vote_t v;
		// one bin filled to the cap
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			v = rgb({5'h1F, 3'($urandom_range(0, 7))}, {5'h1F, 3'($urandom_range(0, 7))},
				{5'h1F, 3'($urandom_range(0, 7))}, i == TABLE_DEPTH - 1);
			send_vote(v);
		end
		// full set, then a last vote in a new bin that must be dropped
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_vote(rgb(8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
				8'($urandom_range(0, 7)), 1'b0));
		send_vote(rgb(8'hFF, 8'hFF, 8'hFF, 1'b1));
		// every table slot a distinct bin, then extra votes past the cap
		for (int i = 0; i < TABLE_DEPTH + 3; i++) begin
			v = rgb({5'(i), 3'($urandom_range(0, 7))}, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), i == TABLE_DEPTH + 2);
			send_vote(v);
		end
		send_set(40);
	endtask

	initial begin
		arst_n     = 1'b0;
		vote       = '0;
		vote_valid = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 15;
		recv_idle_pct = 70;
		test_extremes();
		test_ties();
		test_majority();
		test_random_sets(330);

		send_idle_pct = 70;
		recv_idle_pct = 15;
		test_random_sets(330);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_vote_overflow();
		test_random_sets(250);

		vote_valid <= 1'b0;
		while (expected_means.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
